// ===== hw/rtl/rtcm_pkg.sv =====
// Shared types and constants for the seconds real-time clock block.
// Holds the beat payload structs, command codes, register map and ID bytes.
// No dependencies.
`timescale 1ns / 1ps

package rtcm_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned OFFS_W = 12;
	localparam int unsigned WADDR_W = OFFS_W - 2;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// word addresses (byte offset >> 2)
	localparam logic [WADDR_W-1:0] REG_DATA  = 10'h000;
	localparam logic [WADDR_W-1:0] REG_MATCH = 10'h001;
	localparam logic [WADDR_W-1:0] REG_LOAD  = 10'h002;
	localparam logic [WADDR_W-1:0] REG_CTRL  = 10'h003;
	localparam logic [WADDR_W-1:0] REG_MASK  = 10'h004;
	localparam logic [WADDR_W-1:0] REG_RAW   = 10'h005;
	localparam logic [WADDR_W-1:0] REG_MIS   = 10'h006;
	localparam logic [WADDR_W-1:0] REG_CLEAR = 10'h007;

	// identification window 0xfe0..0xffc: eight words
	localparam logic [WADDR_W-4:0] ID_WIN = 7'h7f;

	typedef struct packed {
		logic [1:0]        func;
		logic [OFFS_W-1:0] offset;
		logic [DATA_W-1:0] write_data;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              irq_level;
	} result_t;

	function automatic logic [7:0] id_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h31;
			3'd1:    b = 8'h10;
			3'd2:    b = 8'h04;
			3'd3:    b = 8'h00;
			3'd4:    b = 8'h0d;
			3'd5:    b = 8'hf0;
			3'd6:    b = 8'h05;
			3'd7:    b = 8'hb1;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== hw/rtl/rtcm_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on rtcm_pkg for field widths.
`timescale 1ns / 1ps

interface rtcm_req_if
	import rtcm_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [OFFS_W-1:0] offset;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, func, offset, write_data, input ready);
	modport sink   (input valid, func, offset, write_data, output ready);
endinterface

interface rtcm_rsp_if
	import rtcm_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              irq_level;

	modport source (output valid, read_data, irq_level, input ready);
	modport sink   (input valid, read_data, irq_level, output ready);
endinterface

// ===== hw/rtl/rtcm_core.sv =====
// Register file, seconds counter and match logic of the real-time clock.
// Processes one beat per advance; depends on rtcm_pkg.
`timescale 1ns / 1ps

module rtcm_core
	import rtcm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	output result_t result
);

	logic [DATA_W-1:0] cnt_q, match_q, load_q, sum_q;
	logic              run_q, mask_q, raw_q;
	logic [DATA_W-1:0] cnt_d, match_d, load_d, sum_d, sum_inc, rd;
	logic              run_d, mask_d, raw_d;
	logic [WADDR_W-1:0] waddr;

	assign waddr   = item.offset[OFFS_W-1:2];
	assign sum_inc = sum_q + DATA_W'(1);

	always_comb begin
		cnt_d   = cnt_q;
		match_d = match_q;
		load_d  = load_q;
		sum_d   = sum_q;
		run_d   = run_q;
		mask_d  = mask_q;
		raw_d   = raw_q;
		rd      = '0;
		case (func_t'(item.func))
			FUNC_TICK: begin
				if (run_q) begin
					cnt_d = cnt_q + DATA_W'(1);
					sum_d = sum_inc;
					if (sum_inc == match_q) begin
						raw_d = 1'b1;
					end
				end
			end
			FUNC_READ: begin
				case (waddr)
					REG_DATA:  rd = sum_q;
					REG_MATCH: rd = match_q;
					REG_LOAD:  rd = load_q;
					REG_CTRL:  rd = DATA_W'(run_q);
					REG_MASK:  rd = DATA_W'(mask_q);
					REG_RAW:   rd = DATA_W'(raw_q);
					REG_MIS:   rd = DATA_W'(raw_q & ~mask_q);
					default: begin
						if (waddr[WADDR_W-1:3] == ID_WIN) begin
							rd = DATA_W'(id_byte(waddr[2:0]));
						end
					end
				endcase
			end
			FUNC_WRITE: begin
				case (waddr)
					REG_MATCH: match_d = item.write_data;
					REG_LOAD: begin
						load_d = item.write_data;
						sum_d  = cnt_q + item.write_data;
					end
					REG_CTRL: begin
						cnt_d = '0;
						sum_d = load_q;
						run_d = item.write_data[0];
					end
					REG_MASK:  mask_d = item.write_data[0];
					REG_CLEAR: begin
						if (item.write_data[0]) begin
							raw_d = 1'b0;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign result.read_data = rd;
	assign result.irq_level = raw_d & ~mask_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			match_q <= '0;
			load_q  <= '0;
			sum_q   <= '0;
			run_q   <= 1'b0;
			mask_q  <= 1'b0;
			raw_q   <= 1'b0;
		end else if (advance) begin
			cnt_q   <= cnt_d;
			match_q <= match_d;
			load_q  <= load_d;
			sum_q   <= sum_d;
			run_q   <= run_d;
			mask_q  <= mask_d;
			raw_q   <= raw_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		sum_q == cnt_q + load_q)
		else $error("data sum out of step with counter and load");

	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(cnt_q) && $stable(raw_q) && $stable(run_q))
		else $error("state changed without a beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !run_q |=> $stable(cnt_q))
		else $error("counter moved while stopped");

endmodule

// ===== hw/rtl/rtc_match_counter_registers.sv =====
// Top level of the seconds real-time clock with match interrupt.
// Request beat register, core logic and response register; needs rtcm_pkg,
// rtcm_req_if, rtcm_rsp_if and rtcm_core.
//
// Usage:
//   req carries one beat per tick, register read or register write
//   (func, offset, write_data); rsp returns exactly one beat per request
//   (read_data, irq_level), in order.
//   Path: a request accepted into the input register is processed by the
//   core and its response is held in the response register.
//   Throughput: one beat per cycle while rsp is not held off; the counter
//   update, the add of the data sum and the match compare all fit between
//   the two registers, with the data sum kept in a register of its own so a
//   tick needs no add of counter and load, only increments and one compare.
//   Stall: while rsp is held off, the response register keeps its beat,
//   the input register holds the next one and req.ready drops once both
//   are full; no beat is lost or repeated.
//   Reset (arst_n low): counter, match, load, control, mask and raw status
//   clear to zero and both registers empty.
`timescale 1ns / 1ps

module rtc_match_counter_registers
	import rtcm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	rtcm_req_if.sink   req,
	rtcm_rsp_if.source rsp
);

	logic    valid_s1, out_valid_q, advance;
	item_t   item_s1;
	result_t result, result_q;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.func       <= req.func;
			item_s1.offset     <= req.offset;
			item_s1.write_data <= req.write_data;
		end
	end

	rtcm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = result_q.read_data;
	assign rsp.irq_level = result_q.irq_level;

	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed beat did not reach response register");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled request beat lost");

	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req.ready)
		else $error("empty input register refused a beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rsp.ready && !advance |=> !out_valid_q)
		else $error("response beat repeated");

endmodule
